// ===== hw/rtl/prefetch_usefulness_set_sampler_assert.svh =====
// Assertion macros shared by the sampler RTL.
`ifndef PREFETCH_USEFULNESS_SET_SAMPLER_ASSERT_SVH
`define PREFETCH_USEFULNESS_SET_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFUS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sampler assertion failed");

// The consequent must hold in the next cycle after the antecedent.
`define PFUS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sampler assertion failed");

`endif

// ===== hw/rtl/pfus_pkg.sv =====
`timescale 1ns / 1ps

package pfus_pkg;

   localparam int ADDR_W        = 64;
   localparam int SET_INDEX_W   = 11;
   localparam int EVICT_BLOCK_W = 58;

endpackage

// ===== hw/rtl/pfus_if.sv =====
`timescale 1ns / 1ps

interface pfus_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [pfus_pkg::ADDR_W-1:0]   addr;
   logic                          is_prefetch;

   modport source (output valid, action, addr, is_prefetch, input ready);
   modport sink   (input valid, action, addr, is_prefetch, output ready);
endinterface

interface pfus_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [pfus_pkg::SET_INDEX_W-1:0]     set_index;
   logic                                 sampled;
   logic                                 hit;
   logic                                 hit_prefetched;
   logic                                 trigger;
   logic                                 evict_valid;
   logic [pfus_pkg::EVICT_BLOCK_W-1:0]   evict_block;

   modport source (output valid, set_index, sampled, hit, hit_prefetched, trigger,
                   evict_valid, evict_block, input ready);
   modport sink   (input valid, set_index, sampled, hit, hit_prefetched, trigger,
                   evict_valid, evict_block, output ready);
endinterface

// ===== hw/rtl/pfus_ram.sv =====
`timescale 1ns / 1ps

module pfus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/prefetch_usefulness_set_sampler.sv =====
`timescale 1ns / 1ps

`include "prefetch_usefulness_set_sampler_assert.svh"

// Sampled-set LRU tag store that tracks whether prefetched blocks get used.
// Input channel req_ch carries one access item: action (0 lookup, 1 lookup and
// update), the byte address and the is_prefetch flag. Output channel rsp_ch
// returns exactly one result item per access, in order.
// Items are taken one at a time. An access to a set that is not tracked goes
// from the divide state back to idle, and its result is loaded into the output
// register as it leaves. A tracked set goes on through the look and write
// states: the set row is read from the tag and metadata RAMs, searched for a
// hit and a victim, and on an update written back, with the result loaded as
// the write state ends. The return to idle waits for a free output register.
// After reset the block sweeps the metadata RAM, one row per cycle, over all
// SAMPLED_SETS rows; req_ch.ready stays low until the sweep is done.
// Results wait in an output register. While rsp_ch is stalled the block still
// accepts one new item and works on it up to the point where its result would
// need the output register.
module prefetch_usefulness_set_sampler #(
   parameter int BLOCK_OFFSET_BITS = 6,
   parameter int CACHE_SET_BITS    = 11,
   parameter int SAMPLE_STRIDE     = 32,
   parameter int SAMPLED_SETS      = 64,
   parameter int SAMPLED_WAYS      = 16
) (
   input  logic              clock,
   input  logic              reset,
   pfus_req_if.sink          req_ch,
   pfus_rsp_if.source        rsp_ch
);

   localparam int TAG_W      = pfus_pkg::ADDR_W - BLOCK_OFFSET_BITS;
   localparam int SET_W      = CACHE_SET_BITS;
   localparam int STRIDE_LOG = $clog2(SAMPLE_STRIDE);
   localparam int DIV_SHIFT  = SET_W + STRIDE_LOG;
   localparam int PROD_W     = 2 * SET_W + 1;
   localparam longint unsigned DIV_MULT_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(SAMPLE_STRIDE) - 64'd1) / 64'(SAMPLE_STRIDE);
   localparam logic [SET_W:0] DIV_MULT = (SET_W + 1)'(DIV_MULT_FULL);
   localparam int ROW_W      = (SAMPLED_SETS > 1) ? $clog2(SAMPLED_SETS) : 1;
   localparam int WAY_W      = $clog2(SAMPLED_WAYS);
   localparam int RANK_W     = WAY_W;
   localparam int META_W     = RANK_W + 3;
   localparam int M_USED     = RANK_W;
   localparam int M_PF       = RANK_W + 1;
   localparam int M_VALID    = RANK_W + 2;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(SAMPLED_WAYS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(SAMPLED_SETS - 1);
   localparam int SIDX_W     = pfus_pkg::SET_INDEX_W;
   localparam int EVB_W      = pfus_pkg::EVICT_BLOCK_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_LOOK  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;

   function automatic logic [RANK_W-1:0] rank_up(input logic [RANK_W-1:0] r);
      rank_up = (r < RANK_MAX) ? r + RANK_W'(1) : RANK_MAX;
   endfunction

   // Control and item registers.
   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  clr_ff, clr_in;
   logic              action_ff, action_in;
   logic              pf_ff, pf_in;
   logic [TAG_W-1:0]  baddr_ff, baddr_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              sampled_ff, sampled_in;
   logic              hit_ff, hit_in;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic [WAY_W-1:0]  vic_way_ff, vic_way_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIDX_W-1:0] o_set_ff, o_set_in;
   logic              o_sampled_ff, o_sampled_in;
   logic              o_hit_ff, o_hit_in;
   logic              o_hit_pf_ff, o_hit_pf_in;
   logic              o_trigger_ff, o_trigger_in;
   logic              o_ev_valid_ff, o_ev_valid_in;
   logic [EVB_W-1:0]  o_ev_block_ff, o_ev_block_in;

   // RAM ports.
   logic                             rd_en;
   logic [ROW_W-1:0]                 rd_addr;
   logic                             meta_wr_en;
   logic [ROW_W-1:0]                 meta_wr_addr;
   logic [SAMPLED_WAYS*META_W-1:0]   meta_wdata;
   logic [SAMPLED_WAYS*META_W-1:0]   meta_rdata;
   logic                             tag_wr_en;
   logic [SAMPLED_WAYS*TAG_W-1:0]    tag_wdata;
   logic [SAMPLED_WAYS*TAG_W-1:0]    tag_rdata;

   // Row view and derived logic.
   logic [TAG_W-1:0]  tag_way   [SAMPLED_WAYS];
   logic              valid_way [SAMPLED_WAYS];
   logic              pf_way    [SAMPLED_WAYS];
   logic              used_way  [SAMPLED_WAYS];
   logic [RANK_W-1:0] rank_way  [SAMPLED_WAYS];

   logic [SET_W-1:0]  req_set;
   logic [PROD_W-1:0] quot_wide;
   logic [SET_W-1:0]  quot;
   logic [SET_W-1:0]  quot_back;
   logic              div_sampled;
   logic              div_track;

   logic              look_hit;
   logic [WAY_W-1:0]  look_hit_way;
   logic              first_found;
   logic [WAY_W-1:0]  first_way;
   logic [WAY_W-1:0]  max_way;
   logic              is_max [SAMPLED_WAYS];

   logic              hw_pf;
   logic              ev_cond;
   logic [TAG_W-1:0]  ev_tag;
   logic [SAMPLED_WAYS*META_W-1:0] new_meta;
   logic [SAMPLED_WAYS*TAG_W-1:0]  new_tag;

   logic              out_free;
   logic              out_load;

   pfus_ram #(
      .WIDTH (SAMPLED_WAYS * META_W),
      .DEPTH (SAMPLED_SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (meta_rdata)
   );

   pfus_ram #(
      .WIDTH (SAMPLED_WAYS * TAG_W),
      .DEPTH (SAMPLED_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (row_ff),
      .wr_data (tag_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tag_rdata)
   );

   // Set index and division by the stride through a reciprocal multiply.
   // The product is registered at acceptance; the quotient is exact for
   // every set index of SET_W bits.
   assign req_set   = req_ch.addr[BLOCK_OFFSET_BITS +: SET_W];
   assign quot_wide = prod_ff >> DIV_SHIFT;
   assign quot      = quot_wide[SET_W-1:0];
   assign quot_back = SET_W'(quot * SAMPLE_STRIDE);
   assign div_sampled = (quot_back == set_ff);
   assign div_track   = div_sampled && (32'(quot) < 32'(SAMPLED_SETS));

   always_comb begin
      for (int w = 0; w < SAMPLED_WAYS; w++) begin
         tag_way[w]   = tag_rdata[w*TAG_W +: TAG_W];
         valid_way[w] = meta_rdata[w*META_W + M_VALID];
         pf_way[w]    = meta_rdata[w*META_W + M_PF];
         used_way[w]  = meta_rdata[w*META_W + M_USED];
         rank_way[w]  = meta_rdata[w*META_W +: RANK_W];
      end
   end

   // Hit search and victim choice over the row that was just read.
   always_comb begin
      look_hit     = 1'b0;
      look_hit_way = '0;
      first_found  = 1'b0;
      first_way    = '0;
      max_way      = '0;
      for (int w = SAMPLED_WAYS - 1; w >= 0; w--) begin
         if (valid_way[w] && (tag_way[w] == baddr_ff)) begin
            look_hit     = 1'b1;
            look_hit_way = WAY_W'(w);
         end
         if (!valid_way[w] || (rank_way[w] == RANK_MAX)) begin
            first_found = 1'b1;
            first_way   = WAY_W'(w);
         end
      end
      // A way is the first highest rank when it beats every way before it
      // and is not beaten by any way after it.
      for (int a = 0; a < SAMPLED_WAYS; a++) begin
         is_max[a] = 1'b1;
         for (int b = 0; b < SAMPLED_WAYS; b++) begin
            if ((b < a) && !(rank_way[a] > rank_way[b])) begin
               is_max[a] = 1'b0;
            end
            if ((b > a) && (rank_way[a] < rank_way[b])) begin
               is_max[a] = 1'b0;
            end
         end
      end
      for (int a = SAMPLED_WAYS - 1; a >= 0; a--) begin
         if (is_max[a]) begin
            max_way = WAY_W'(a);
         end
      end
   end

   // New row contents for an update.
   always_comb begin
      logic [RANK_W-1:0] tgt;
      logic              nv;
      logic              npf;
      logic              nused;
      logic [RANK_W-1:0] nrank;
      logic [TAG_W-1:0]  ntag;
      hw_pf   = pf_way[hit_way_ff];
      ev_cond = valid_way[vic_way_ff] && pf_way[vic_way_ff] && !used_way[vic_way_ff];
      ev_tag  = tag_way[vic_way_ff];
      tgt     = rank_way[hit_way_ff];
      for (int a = 0; a < SAMPLED_WAYS; a++) begin
         nv    = valid_way[a];
         npf   = pf_way[a];
         nused = used_way[a];
         nrank = rank_way[a];
         ntag  = tag_way[a];
         if (hit_ff) begin
            if (WAY_W'(a) == hit_way_ff) begin
               nrank = '0;
               if (pf_way[a]) begin
                  nused = 1'b1;
               end else begin
                  npf   = pf_ff;
                  nused = 1'b0;
               end
            end else if (valid_way[a] && (rank_way[a] < tgt)) begin
               nrank = rank_up(rank_way[a]);
            end
         end else begin
            if (WAY_W'(a) == vic_way_ff) begin
               nv    = 1'b1;
               nrank = '0;
               ntag  = baddr_ff;
               npf   = pf_ff;
               nused = 1'b0;
            end else if (valid_way[a]) begin
               nrank = rank_up(rank_way[a]);
            end
         end
         new_meta[a*META_W +: META_W] = {nv, npf, nused, nrank};
         new_tag[a*TAG_W +: TAG_W]    = ntag;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_load = ((state_ff == ST_DIV) && !div_track && out_free) ||
                     ((state_ff == ST_WRITE) && out_free);

   // Items are handled one at a time, so a row written back in the write
   // state is always in the RAM before the next item reads it.
   assign rd_en        = (state_ff == ST_DIV) && div_track;
   assign rd_addr      = ROW_W'(quot);
   assign meta_wr_en   = (state_ff == ST_CLEAR) ||
                         ((state_ff == ST_WRITE) && out_free && action_ff);
   assign meta_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : row_ff;
   assign meta_wdata   = (state_ff == ST_CLEAR) ? '0 : new_meta;
   assign tag_wr_en    = (state_ff == ST_WRITE) && out_free && action_ff && !hit_ff;
   assign tag_wdata    = new_tag;

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      action_in  = action_ff;
      pf_in      = pf_ff;
      baddr_in   = baddr_ff;
      set_in     = set_ff;
      prod_in    = prod_ff;
      row_in     = row_ff;
      sampled_in = sampled_ff;
      hit_in     = hit_ff;
      hit_way_in = hit_way_ff;
      vic_way_in = vic_way_ff;

      o_set_in      = o_set_ff;
      o_sampled_in  = o_sampled_ff;
      o_hit_in      = o_hit_ff;
      o_hit_pf_in   = o_hit_pf_ff;
      o_trigger_in  = o_trigger_ff;
      o_ev_valid_in = o_ev_valid_ff;
      o_ev_block_in = o_ev_block_ff;
      rsp_valid_in  = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         o_set_in     = SIDX_W'(set_ff);
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ROW_W'(1);
            if (clr_ff == ROW_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               action_in = req_ch.action;
               pf_in     = req_ch.is_prefetch;
               baddr_in  = req_ch.addr[pfus_pkg::ADDR_W-1:BLOCK_OFFSET_BITS];
               set_in    = req_set;
               prod_in   = PROD_W'(req_set) * PROD_W'(DIV_MULT);
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            row_in     = ROW_W'(quot);
            sampled_in = div_sampled;
            if (div_track) begin
               state_in = ST_LOOK;
            end else if (out_free) begin
               o_sampled_in  = div_sampled;
               o_hit_in      = 1'b0;
               o_hit_pf_in   = 1'b0;
               o_trigger_in  = 1'b1;
               o_ev_valid_in = 1'b0;
               o_ev_block_in = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_LOOK: begin
            hit_in     = look_hit;
            hit_way_in = look_hit_way;
            vic_way_in = first_found ? first_way : max_way;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               o_sampled_in  = sampled_ff;
               o_hit_in      = hit_ff;
               o_hit_pf_in   = hit_ff && hw_pf;
               o_trigger_in  = !(hit_ff && !hw_pf);
               o_ev_valid_in = action_ff && !hit_ff && ev_cond;
               o_ev_block_in = (action_ff && !hit_ff && ev_cond) ? EVB_W'(ev_tag) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      pf_ff         <= pf_in;
      baddr_ff      <= baddr_in;
      set_ff        <= set_in;
      prod_ff       <= prod_in;
      row_ff        <= row_in;
      sampled_ff    <= sampled_in;
      hit_ff        <= hit_in;
      hit_way_ff    <= hit_way_in;
      vic_way_ff    <= vic_way_in;
      o_set_ff      <= o_set_in;
      o_sampled_ff  <= o_sampled_in;
      o_hit_ff      <= o_hit_in;
      o_hit_pf_ff   <= o_hit_pf_in;
      o_trigger_ff  <= o_trigger_in;
      o_ev_valid_ff <= o_ev_valid_in;
      o_ev_block_ff <= o_ev_block_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.set_index      = o_set_ff;
   assign rsp_ch.sampled        = o_sampled_ff;
   assign rsp_ch.hit            = o_hit_ff;
   assign rsp_ch.hit_prefetched = o_hit_pf_ff;
   assign rsp_ch.trigger        = o_trigger_ff;
   assign rsp_ch.evict_valid    = o_ev_valid_ff;
   assign rsp_ch.evict_block    = o_ev_block_ff;

   `PFUS_ASSERT_SAME(a_no_accept_in_sweep, clock, reset,
      state_ff == ST_CLEAR, !req_ch.ready)
   `PFUS_ASSERT_SAME(a_evict_on_update_miss, clock, reset,
      out_load && o_ev_valid_in, action_ff && !hit_ff && (state_ff == ST_WRITE))
   `PFUS_ASSERT_SAME(a_hit_needs_sampled, clock, reset,
      rsp_ch.valid && (rsp_ch.hit || !rsp_ch.trigger), rsp_ch.sampled && rsp_ch.hit)
   `PFUS_ASSERT_NEXT(a_load_shows_result, clock, reset,
      out_load, rsp_ch.valid)

endmodule

// ===== bench/pfus_sampler_check.sv =====
`timescale 1ns / 1ps

module pfus_sampler_check #(
   parameter int BLOCK_OFFSET_BITS = 6,
   parameter int CACHE_SET_BITS    = 11,
   parameter int SAMPLE_STRIDE     = 32,
   parameter int SAMPLED_SETS      = 64,
   parameter int SAMPLED_WAYS      = 16
) (
   input  logic  clock,
   input  logic  reset,
   pfus_req_if   req,
   pfus_rsp_if   rsp,
   output int    fails,
   output int    pending
);

   localparam int TAG_W   = pfus_pkg::ADDR_W - BLOCK_OFFSET_BITS;
   localparam int ENTRIES = SAMPLED_SETS * SAMPLED_WAYS;

   typedef struct packed {
      logic [pfus_pkg::SET_INDEX_W-1:0]   set_index;
      logic                               sampled;
      logic                               hit;
      logic                               hit_prefetched;
      logic                               trigger;
      logic                               evict_valid;
      logic [pfus_pkg::EVICT_BLOCK_W-1:0] evict_block;
   } sampler_result_type;

   logic [TAG_W-1:0] way_tag   [ENTRIES];
   bit               way_valid [ENTRIES];
   int unsigned      way_rank  [ENTRIES];
   bit               way_pf    [ENTRIES];
   bit               way_used  [ENTRIES];

   sampler_result_type expected_results[$];
   int                 error_total = 0;

   function automatic int unsigned age_rank(input int unsigned r);
      return (r < SAMPLED_WAYS - 1) ? r + 1 : SAMPLED_WAYS - 1;
   endfunction

   // Updates the shadow tag store and returns what the block should answer.
   function automatic sampler_result_type predict_access(input bit act,
                                                   input logic [pfus_pkg::ADDR_W-1:0] a,
                                                   input bit pf_in);
      logic [TAG_W-1:0]   blk;
      int                 set;
      int                 row;
      int                 base;
      int                 hit_way;
      int                 victim;
      int unsigned        hit_rank;
      sampler_result_type r;
      blk = a[pfus_pkg::ADDR_W-1:BLOCK_OFFSET_BITS];
      set = int'(blk[CACHE_SET_BITS-1:0]);
      row = set / SAMPLE_STRIDE;
      r = '0;
      r.set_index = pfus_pkg::SET_INDEX_W'(set);
      r.sampled   = (set % SAMPLE_STRIDE) == 0;
      r.trigger   = 1'b1;
      if (r.sampled && row < SAMPLED_SETS) begin
         base    = row * SAMPLED_WAYS;
         hit_way = -1;
         for (int w = 0; w < SAMPLED_WAYS; w++) begin
            if (hit_way < 0 && way_valid[base+w] && way_tag[base+w] == blk) hit_way = w;
         end
         if (hit_way >= 0) begin
            r.hit            = 1'b1;
            r.hit_prefetched = way_pf[base+hit_way];
            r.trigger        = way_pf[base+hit_way];
         end
         if (act && hit_way >= 0) begin
            hit_rank = way_rank[base+hit_way];
            for (int w = 0; w < SAMPLED_WAYS; w++) begin
               if (way_valid[base+w] && way_rank[base+w] < hit_rank)
                  way_rank[base+w] = age_rank(way_rank[base+w]);
            end
            way_rank[base+hit_way] = 0;
            if (way_pf[base+hit_way]) begin
               way_used[base+hit_way] = 1'b1;
            end else begin
               way_pf[base+hit_way]   = pf_in;
               way_used[base+hit_way] = 1'b0;
            end
         end else if (act) begin
            // Prefer an empty way or one already at the oldest rank.
            victim = -1;
            for (int w = 0; w < SAMPLED_WAYS; w++) begin
               if (victim < 0 && (!way_valid[base+w] || way_rank[base+w] == SAMPLED_WAYS - 1))
                  victim = w;
            end
            if (victim < 0) begin
               victim = 0;
               for (int w = 1; w < SAMPLED_WAYS; w++) begin
                  if (way_rank[base+w] > way_rank[base+victim]) victim = w;
               end
            end
            for (int w = 0; w < SAMPLED_WAYS; w++) begin
               if (way_valid[base+w] && w != victim)
                  way_rank[base+w] = age_rank(way_rank[base+w]);
            end
            if (way_valid[base+victim] && way_pf[base+victim] && !way_used[base+victim]) begin
               r.evict_valid = 1'b1;
               r.evict_block = pfus_pkg::EVICT_BLOCK_W'(way_tag[base+victim]);
            end
            way_valid[base+victim] = 1'b1;
            way_rank[base+victim]  = 0;
            way_tag[base+victim]   = blk;
            way_pf[base+victim]    = pf_in;
            way_used[base+victim]  = 1'b0;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] seen,
                                  input logic [63:0] wanted);
      $display("%0t ns: sampler %s: got %0h, expected %0h", $time, what, seen, wanted);
      error_total++;
   endtask

   always @(posedge clock) begin
      sampler_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            way_valid[i] = 1'b0;
            way_rank[i]  = 0;
            way_pf[i]    = 1'b0;
            way_used[i]  = 1'b0;
         end
         expected_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no access waiting", 64'(rsp.set_index), 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp.set_index !== want.set_index)
                  report_mismatch("set_index", 64'(rsp.set_index), 64'(want.set_index));
               if (rsp.sampled !== want.sampled)
                  report_mismatch("sampled", 64'(rsp.sampled), 64'(want.sampled));
               if (rsp.hit !== want.hit)
                  report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
               if (rsp.hit_prefetched !== want.hit_prefetched)
                  report_mismatch("hit_prefetched", 64'(rsp.hit_prefetched),
                                  64'(want.hit_prefetched));
               if (rsp.trigger !== want.trigger)
                  report_mismatch("trigger", 64'(rsp.trigger), 64'(want.trigger));
               if (rsp.evict_valid !== want.evict_valid)
                  report_mismatch("evict_valid", 64'(rsp.evict_valid), 64'(want.evict_valid));
               if (rsp.evict_block !== want.evict_block)
                  report_mismatch("evict_block", 64'(rsp.evict_block), 64'(want.evict_block));
            end
         end
         if (req.valid && req.ready)
            expected_results.push_back(predict_access(req.action, req.addr, req.is_prefetch));
      end
      fails   <= error_total;
      pending <= expected_results.size();
   end

endmodule

// ===== bench/tb_prefetch_usefulness_set_sampler.sv =====
`timescale 1ns / 1ps

module tb_prefetch_usefulness_set_sampler;

   localparam int BLOCK_OFFSET_BITS = 6;
   localparam int CACHE_SET_BITS    = 11;
   localparam int SAMPLE_STRIDE     = 32;
   localparam int SAMPLED_SETS      = 64;
   localparam int SAMPLED_WAYS      = 16;
   localparam int UPPER_W           = pfus_pkg::ADDR_W - BLOCK_OFFSET_BITS - CACHE_SET_BITS;
   localparam int RANDOM_ACCESSES   = 1576;
   localparam int CALM_TAIL         = 200;
   localparam int QUIET_LIMIT       = 1000;
   localparam int POOL_SIZE         = 24;

   localparam bit LOOKUP = 1'b0;
   localparam bit UPDATE = 1'b1;

   logic clock;
   logic reset;
   int   fails;
   int   pending;
   int   quiet_cycles = 0;
   int   stall_left   = 0;
   bit   rsp_stalls_on = 1'b1;

   logic [UPPER_W-1:0] tag_pool [POOL_SIZE];
   int                 hot_rows [4];

   pfus_req_if req_ch ();
   pfus_rsp_if rsp_ch ();

   prefetch_usefulness_set_sampler #(
      .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS),
      .CACHE_SET_BITS   (CACHE_SET_BITS),
      .SAMPLE_STRIDE    (SAMPLE_STRIDE),
      .SAMPLED_SETS     (SAMPLED_SETS),
      .SAMPLED_WAYS     (SAMPLED_WAYS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   pfus_sampler_check #(
      .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS),
      .CACHE_SET_BITS   (CACHE_SET_BITS),
      .SAMPLE_STRIDE    (SAMPLE_STRIDE),
      .SAMPLED_SETS     (SAMPLED_SETS),
      .SAMPLED_WAYS     (SAMPLED_WAYS)
   ) u_check (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .fails  (fails),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [pfus_pkg::ADDR_W-1:0] compose_addr(
      input logic [UPPER_W-1:0] upper, input int set, input int offset);
      return {upper, CACHE_SET_BITS'(set), BLOCK_OFFSET_BITS'(offset)};
   endfunction

   task automatic send_access(input bit act, input logic [pfus_pkg::ADDR_W-1:0] a,
                              input bit pf, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.addr        <= a;
      req_ch.is_prefetch <= pf;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Result side back-pressure: rsp_ch.ready is dropped in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 2);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [pfus_pkg::ADDR_W-1:0] a;
      int                          set;
      int                          kind;
      bit                          gaps;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= LOOKUP;
      req_ch.addr        <= '0;
      req_ch.is_prefetch <= 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = UPPER_W'({$urandom, $urandom});
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: address extremes, the last tracked row, and one row filled with
      // prefetches until a never-used block gets pushed out.
      send_access(LOOKUP, '0, 1'b0, 1'b1);
      send_access(UPDATE, '1, 1'b1, 1'b1);
      send_access(UPDATE, compose_addr('1, (SAMPLED_SETS - 1) * SAMPLE_STRIDE, 63), 1'b1, 1'b1);
      send_access(LOOKUP, compose_addr('1, (SAMPLED_SETS - 1) * SAMPLE_STRIDE, 0), 1'b0, 1'b1);
      for (int k = 1; k <= SAMPLED_WAYS; k++)
         send_access(UPDATE, compose_addr(UPPER_W'(k), 0, k), 1'b1, 1'b1);
      send_access(UPDATE, compose_addr(UPPER_W'(2), 0, 0), 1'b0, 1'b1);
      send_access(UPDATE, compose_addr(UPPER_W'(17), 0, 0), 1'b0, 1'b1);
      send_access(LOOKUP, compose_addr(UPPER_W'(17), 0, 5), 1'b1, 1'b1);
      send_access(UPDATE, compose_addr(UPPER_W'(17), 0, 9), 1'b1, 1'b1);

      // Random: mostly a small working set of tracked rows and tags so that rows
      // fill up, hit and evict; the rest is untracked sets and raw noise.
      gaps = 1'b1;
      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         if (n % 200 == 0) begin
            for (int h = 0; h < 4; h++) hot_rows[h] = $urandom_range(0, SAMPLED_SETS - 1);
         end
         if (n % 100 == 0) begin
            gaps = (n < RANDOM_ACCESSES - CALM_TAIL) ? ($urandom_range(0, 2) != 0) : 1'b0;
            rsp_stalls_on <= gaps;
         end
         kind = $urandom_range(0, 19);
         if (kind < 3) begin
            a = {$urandom, $urandom};
         end else begin
            set = hot_rows[$urandom_range(0, 3)] * SAMPLE_STRIDE;
            if (kind == 3) set = set + $urandom_range(1, SAMPLE_STRIDE - 1);
            a = compose_addr(tag_pool[$urandom_range(0, POOL_SIZE - 1)], set, $urandom);
         end
         send_access(($urandom_range(0, 9) < 7) ? UPDATE : LOOKUP, a,
                     1'($urandom_range(0, 1)), gaps);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fails == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
